[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file servo_ramp_weight_watch.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/srww_pkg.sv]
// Package: payload types, status codes and constants of the servo ramp controller.
`timescale 1ns / 1ps
package srww_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned PerW   = 16;
  localparam int unsigned WgtW   = 16;
  localparam int unsigned ErrW   = 8;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [PosW-1:0] ServoMinRst  = 12'd544;
  localparam logic [PosW-1:0] ServoMaxRst  = 12'd2400;
  localparam logic [WgtW-1:0] EpsilonRst   = 16'd10;
  localparam logic [PosW-1:0] StartPosRst  = 12'd1500;

  localparam logic ActMove = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam logic [1:0] SampleValid = 2'd1;
  localparam logic [1:0] SampleError = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POS_LO    = 2'd0,
    CFG_POS_HI    = 2'd1,
    CFG_EPSILON   = 2'd2,
    CFG_START_POS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_REACHED    = 3'd1,
    ST_RANGE      = 3'd2,
    ST_NO_CUP     = 3'd3,
    ST_STABLE     = 3'd4,
    ST_NOT_STABLE = 3'd5,
    ST_ABORTED    = 3'd6,
    ST_SCALE_ERR  = 3'd7
  } status_e;

  typedef struct packed {
    logic                   action;
    logic [PosW-1:0]        target_pos;
    logic [PerW-1:0]        step_period;
    logic                   watch_cup;
    logic                   want_stable;
    logic                   abort_enable;
    logic                   abort_request;
    logic [1:0]             sample_status;
    logic signed [WgtW-1:0] sample_weight;
    logic [ErrW-1:0]        sample_error;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]        servo_pos;
    logic                   busy_res;
    status_e                status;
    logic signed [WgtW-1:0] stable_value;
    logic [ErrW-1:0]        error_code;
  } out_item_t;

endpackage

[sv/servo_ramp_weight_watch.sv]
// Top level: servo ramp controller with scale watch, input and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Servo ramp controller that watches a scale. A move transfer (action 0) latches
// a target pulse width, a step period in milliseconds and the watch_cup,
// want_stable and abort_enable flags; a target outside the window from the low
// limit to the high limit fails at once with status 2, and a target equal to the
// current position finishes at once with status 1. A tick transfer (action 1)
// during a move counts toward the step period; on a step tick the block checks
// the abort request, then the scale sample (error -> 7, weight below the cup
// floor -> 3, three equal valid samples -> 4), otherwise moves one microsecond
// toward the target and ends with 1 (or 5 when a stable weight was wanted) on
// arrival. Each input transfer yields exactly one result transfer. Throughput is
// one item per clock while the output is not stalled; each item passes through
// the input register, then the result register. Input is taken while a result
// waits on the output as long as the input register is empty or can move forward.
// Configuration writes (low limit, high limit, cup floor, start position; the
// last also reloads the position) are expected only while the block is idle.
module servo_ramp_weight_watch
  import srww_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  cfg_idx_e        cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  // input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_item_t        in_item_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o
);

  // Stage 1: input register
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q, s1_item_d;
  // Stage 2: result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic      advance;   // stage 1 may move into the result register
  logic      in_xfer;
  out_item_t res;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // State update happens exactly when a stage-1 item moves on.
  srww_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_fire_i (s1_valid_q && advance),
    .item_i      (s1_item_q),
    .res_o       (res)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_item_d   = s1_item_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      out_item_d  = res;
      s1_valid_d  = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_d = 1'b1;
      s1_item_d  = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    s1_item_q  <= s1_item_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A stalled input item is neither lost nor overwritten.
  `ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !advance, s1_valid_q && $stable(s1_item_q))
  // A terminal status always means the move is over.
  `ASSERT_IMP(a_done_not_busy, clk_i, rst_ni, out_valid_o && out_item_o.status != ST_IDLE, !out_item_o.busy_res)
  // Stable weight is reported only with the stable status.
  `ASSERT_IMP(a_stable_only, clk_i, rst_ni, out_valid_o && out_item_o.status != ST_STABLE, out_item_o.stable_value == '0)
  // Scale error code is reported only with the scale error status.
  `ASSERT_IMP(a_err_only, clk_i, rst_ni, out_valid_o && out_item_o.status != ST_SCALE_ERR, out_item_o.error_code == '0)

endmodule

[sv/srww_core.sv]
// Move/step state and its update for one item.
`timescale 1ns / 1ps
module srww_core
  import srww_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                item_fire_i,
  input  in_item_t            item_i,
  output out_item_t           res_o
);

  localparam int unsigned FlagWatch  = 0;
  localparam int unsigned FlagStable = 1;
  localparam int unsigned FlagAbort  = 2;

  logic [PosW-1:0]        pos_lo_q, pos_lo_d;
  logic [PosW-1:0]        pos_hi_q, pos_hi_d;
  logic signed [WgtW-1:0] eps_q, eps_d;
  logic [PosW-1:0]        start_pos_q, start_pos_d;

  logic [PosW-1:0]        pos_q, pos_d;
  logic [PosW-1:0]        tgt_q, tgt_d;
  logic                   moving_q, moving_d;
  logic [PerW-1:0]        period_q, period_d;
  logic [PerW-1:0]        tick_q, tick_d;
  logic [2:0]             flags_q, flags_d;
  logic signed [WgtW-1:0] w1_q, w1_d;
  logic signed [WgtW-1:0] w2_q, w2_d;
  logic [1:0]             held_q, held_d;

  always_comb begin
    logic [PerW:0]   count;
    logic            step_tick;
    logic            stop;
    logic [PosW-1:0] pos_n;

    pos_lo_d    = pos_lo_q;
    pos_hi_d    = pos_hi_q;
    eps_d       = eps_q;
    start_pos_d = start_pos_q;
    pos_d       = pos_q;
    tgt_d       = tgt_q;
    moving_d    = moving_q;
    period_d    = period_q;
    tick_d      = tick_q;
    flags_d     = flags_q;
    w1_d        = w1_q;
    w2_d        = w2_q;
    held_d      = held_q;

    res_o.status       = ST_IDLE;
    res_o.stable_value = '0;
    res_o.error_code   = '0;

    count     = {1'b0, tick_q} + {{PerW{1'b0}}, 1'b1};
    step_tick = (count >= {1'b0, period_q});
    stop      = 1'b0;
    pos_n     = pos_q;

    if (item_fire_i) begin
      if (item_i.action == ActMove) begin
        moving_d = 1'b0;
        if (item_i.target_pos < pos_lo_q || item_i.target_pos > pos_hi_q) begin
          res_o.status = ST_RANGE;
        end else if (item_i.target_pos == pos_q) begin
          res_o.status = ST_REACHED;
        end else begin
          tgt_d    = item_i.target_pos;
          period_d = item_i.step_period;
          flags_d  = {item_i.abort_enable, item_i.want_stable, item_i.watch_cup};
          tick_d   = '0;
          held_d   = '0;
          w1_d     = '0;
          w2_d     = '0;
          moving_d = 1'b1;
        end
      end else if (moving_q) begin
        if (!step_tick) begin
          tick_d = count[PerW-1:0];
        end else begin
          tick_d = '0;
          // Priority: abort, scale checks, then one microsecond step.
          if (flags_q[FlagAbort] && item_i.abort_request) begin
            moving_d     = 1'b0;
            res_o.status = ST_ABORTED;
            stop         = 1'b1;
          end else if (flags_q[FlagWatch] || flags_q[FlagStable]) begin
            if (item_i.sample_status == SampleValid) begin
              if (flags_q[FlagWatch] && (item_i.sample_weight < eps_q)) begin
                moving_d     = 1'b0;
                res_o.status = ST_NO_CUP;
                stop         = 1'b1;
              end else if (flags_q[FlagStable]) begin
                if (held_q >= 2'd2 && w2_q == w1_q && w1_q == item_i.sample_weight) begin
                  moving_d           = 1'b0;
                  res_o.status       = ST_STABLE;
                  res_o.stable_value = item_i.sample_weight;
                  stop               = 1'b1;
                end else begin
                  w2_d = w1_q;
                  w1_d = item_i.sample_weight;
                  if (held_q < 2'd2) begin
                    held_d = held_q + 2'd1;
                  end
                end
              end
            end else if (item_i.sample_status == SampleError) begin
              moving_d         = 1'b0;
              res_o.status     = ST_SCALE_ERR;
              res_o.error_code = item_i.sample_error;
              stop             = 1'b1;
            end
          end
          if (!stop) begin
            if (pos_q < tgt_q) begin
              pos_n = pos_q + {{(PosW-1){1'b0}}, 1'b1};
            end else if (pos_q > tgt_q) begin
              pos_n = pos_q - {{(PosW-1){1'b0}}, 1'b1};
            end
            pos_d = pos_n;
            if (pos_n == tgt_q) begin
              moving_d     = 1'b0;
              res_o.status = flags_q[FlagStable] ? ST_NOT_STABLE : ST_REACHED;
            end
          end
        end
      end
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POS_LO:    pos_lo_d = cfg_wdata_i[PosW-1:0];
        CFG_POS_HI:    pos_hi_d = cfg_wdata_i[PosW-1:0];
        CFG_EPSILON:   eps_d    = $signed(cfg_wdata_i[WgtW-1:0]);
        CFG_START_POS: begin
          start_pos_d = cfg_wdata_i[PosW-1:0];
          pos_d       = cfg_wdata_i[PosW-1:0];
        end
        default: ;
      endcase
    end

    res_o.servo_pos = pos_d;
    res_o.busy_res  = moving_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lo_q    <= ServoMinRst;
      pos_hi_q    <= ServoMaxRst;
      eps_q       <= $signed(EpsilonRst);
      start_pos_q <= StartPosRst;
      pos_q       <= StartPosRst;
      tgt_q       <= '0;
      moving_q    <= 1'b0;
      period_q    <= '0;
      tick_q      <= '0;
      flags_q     <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
      held_q      <= '0;
    end else begin
      pos_lo_q    <= pos_lo_d;
      pos_hi_q    <= pos_hi_d;
      eps_q       <= eps_d;
      start_pos_q <= start_pos_d;
      pos_q       <= pos_d;
      tgt_q       <= tgt_d;
      moving_q    <= moving_d;
      period_q    <= period_d;
      tick_q      <= tick_d;
      flags_q     <= flags_d;
      w1_q        <= w1_d;
      w2_q        <= w2_d;
      held_q      <= held_d;
    end
  end

endmodule
